// File: rtl/core/csb_pkg.sv
// ============================================================================
// csb_pkg
// Shared types and operation codes for the cursor sequence buffer.
// ============================================================================
package csb_pkg;

    localparam logic [2:0] OP_START   = 3'd0;
    localparam logic [2:0] OP_ADVANCE = 3'd1;
    localparam logic [2:0] OP_INSERT  = 3'd2;
    localparam logic [2:0] OP_ATTACH  = 3'd3;
    localparam logic [2:0] OP_REMOVE  = 3'd4;

    typedef struct packed {
        logic [2:0]  operation;
        logic [31:0] entry_value;
    } item_t;

    typedef struct packed {
        logic [31:0] current_value;
        logic        has_item;
        logic [4:0]  entry_count;
        logic        error_flag;
    } result_t;

    typedef struct packed {
        logic open_gap;
        logic close_gap;
    } shift_cmd_t;

endpackage

// File: rtl/core/cursor_sequence_buffer_top.sv
// An item beat is taken only while idle: the cells shift and the cursor moves as
// it is taken, the current entry ripples through the collect register of each
// cell, and the result register is loaded when no earlier result is stalled.
// A waiting result does not block the next item beat.
// Reset clears count and cursor; entry storage is not reset.
// ============================================================================
// cursor_sequence_buffer_top
// Ordered store with one cursor, built as a row of shifting cells with a
// collect chain that delivers the current entry.
// ============================================================================
module cursor_sequence_buffer_top #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  csb_pkg::item_t    item,
    output logic              result_valid,
    input  logic              result_stall,
    output csb_pkg::result_t  result
);

    localparam int IW = $clog2(DEPTH);
    localparam int CW = $clog2(DEPTH + 1);

    csb_pkg::shift_cmd_t    cmd;
    logic [IW-1:0]          pos;
    logic [CW-1:0]          cursor;
    logic [63:0]            value_wide;
    logic [DATA_WIDTH-1:0]  ins_value;
    logic [DATA_WIDTH-1:0]  cell_data [DEPTH];
    logic [DATA_WIDTH-1:0]  col_chain [DEPTH+1];

    assign value_wide   = 64'(item.entry_value);
    assign ins_value    = value_wide[DATA_WIDTH-1:0];
    assign col_chain[0] = '0;

    csb_ctrl #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH),
        .IW         (IW),
        .CW         (CW)
    ) u_ctrl (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result),
        .cmd          (cmd),
        .pos          (pos),
        .cursor       (cursor),
        .col_last     (col_chain[DEPTH])
    );

    for (genvar i = 0; i < DEPTH; i++)
    begin : g_cell
        logic [DATA_WIDTH-1:0] left_data;
        logic [DATA_WIDTH-1:0] right_data;

        if (i == 0)
        begin : g_first
            assign left_data = cell_data[i];
        end
        else
        begin : g_inner_left
            assign left_data = cell_data[i-1];
        end

        if (i == DEPTH - 1)
        begin : g_last
            assign right_data = cell_data[i];
        end
        else
        begin : g_inner_right
            assign right_data = cell_data[i+1];
        end

        csb_cell #(
            .DATA_WIDTH (DATA_WIDTH),
            .IW         (IW),
            .CW         (CW),
            .INDEX      (i)
        ) u_cell (
            .clk        (clk),
            .cmd        (cmd),
            .pos        (pos),
            .ins_value  (ins_value),
            .left_data  (left_data),
            .right_data (right_data),
            .cursor     (cursor),
            .col_in     (col_chain[i]),
            .data       (cell_data[i]),
            .col_out    (col_chain[i+1])
        );
    end

endmodule

// File: rtl/core/csb_cell.sv
// ============================================================================
// csb_cell
// One storage cell of the row: holds an entry, shifts with its neighbours
// and passes the current entry down the collect chain.
// ============================================================================
module csb_cell #(
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 4,
    parameter int CW         = 5,
    parameter int INDEX      = 0
) (
    input  logic                   clk,
    input  csb_pkg::shift_cmd_t    cmd,
    input  logic [IW-1:0]          pos,
    input  logic [DATA_WIDTH-1:0]  ins_value,
    input  logic [DATA_WIDTH-1:0]  left_data,
    input  logic [DATA_WIDTH-1:0]  right_data,
    input  logic [CW-1:0]          cursor,
    input  logic [DATA_WIDTH-1:0]  col_in,
    output logic [DATA_WIDTH-1:0]  data,
    output logic [DATA_WIDTH-1:0]  col_out
);

    logic [DATA_WIDTH-1:0] data_reg;
    logic [DATA_WIDTH-1:0] data_next;
    logic [DATA_WIDTH-1:0] col_reg;
    logic [DATA_WIDTH-1:0] col_next;
    logic                  is_current;

    assign is_current = (cursor == CW'(INDEX + 1));

    always_comb
    begin
        data_next = data_reg;
        if (cmd.open_gap)
        begin
            if (IW'(INDEX) > pos)
            begin
                data_next = left_data;
            end
            else if (IW'(INDEX) == pos)
            begin
                data_next = ins_value;
            end
        end
        else if (cmd.close_gap)
        begin
            if (IW'(INDEX) >= pos)
            begin
                data_next = right_data;
            end
        end
        col_next = is_current ? data_reg : col_in;
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        col_reg  <= col_next;
    end

    assign data    = data_reg;
    assign col_out = col_reg;

endmodule

// File: rtl/core/csb_ctrl.sv
// ============================================================================
// csb_ctrl
// Operation decode, count and cursor upkeep, beat handshakes and the
// result register of the cursor sequence buffer.
// ============================================================================
module csb_ctrl #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int IW         = 4,
    parameter int CW         = 5
) (
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   item_valid,
    output logic                   item_stall,
    input  csb_pkg::item_t         item,
    output logic                   result_valid,
    input  logic                   result_stall,
    output csb_pkg::result_t       result,
    output csb_pkg::shift_cmd_t    cmd,
    output logic [IW-1:0]          pos,
    output logic [CW-1:0]          cursor,
    input  logic [DATA_WIDTH-1:0]  col_last
);

    localparam logic ST_IDLE = 1'b0;
    localparam logic ST_RUN  = 1'b1;

    logic              state_reg;
    logic              state_next;
    logic [CW-1:0]     wait_reg;
    logic [CW-1:0]     wait_next;
    logic [CW-1:0]     count_reg;
    logic [CW-1:0]     count_next;
    logic [CW-1:0]     cursor_reg;
    logic [CW-1:0]     cursor_next;
    logic              err_reg;
    logic              err_next;
    logic              result_valid_reg;
    logic              result_valid_next;
    csb_pkg::result_t  result_reg;
    csb_pkg::result_t  result_next;

    logic                accept;
    logic                has;
    logic                full;
    logic                done;
    logic                load;
    logic                dec_err;
    logic [CW-1:0]       dec_count;
    logic [CW-1:0]       dec_cursor;
    logic [IW-1:0]       dec_pos;
    csb_pkg::shift_cmd_t dec_cmd;
    logic [63:0]         col_wide;

    assign item_stall = (state_reg != ST_IDLE);
    assign accept     = item_valid && (state_reg == ST_IDLE);
    assign has        = (cursor_reg != '0);
    assign full       = (count_reg == CW'(DEPTH));
    assign done       = (state_reg == ST_RUN) && (wait_reg == CW'(DEPTH));
    assign load       = done && (!result_valid_reg || !result_stall);
    assign col_wide   = 64'(col_last);

    always_comb
    begin
        dec_err    = 1'b0;
        dec_count  = count_reg;
        dec_cursor = cursor_reg;
        dec_pos    = '0;
        dec_cmd    = '0;
        case (item.operation)
            csb_pkg::OP_START:
            begin
                dec_cursor = (count_reg != '0) ? CW'(1) : '0;
            end
            csb_pkg::OP_ADVANCE:
            begin
                if (!has)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    dec_cursor = (cursor_reg < count_reg) ? cursor_reg + CW'(1) : '0;
                end
            end
            csb_pkg::OP_INSERT:
            begin
                if (full)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    dec_pos          = has ? IW'(cursor_reg - CW'(1)) : '0;
                    dec_cmd.open_gap = 1'b1;
                    dec_count        = count_reg + CW'(1);
                    dec_cursor       = CW'(dec_pos) + CW'(1);
                end
            end
            csb_pkg::OP_ATTACH:
            begin
                if (full)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    dec_pos          = has ? IW'(cursor_reg) : IW'(count_reg);
                    dec_cmd.open_gap = 1'b1;
                    dec_count        = count_reg + CW'(1);
                    dec_cursor       = CW'(dec_pos) + CW'(1);
                end
            end
            csb_pkg::OP_REMOVE:
            begin
                if (!has)
                begin
                    dec_err = 1'b1;
                end
                else
                begin
                    dec_pos           = IW'(cursor_reg - CW'(1));
                    dec_cmd.close_gap = 1'b1;
                    dec_count         = count_reg - CW'(1);
                    dec_cursor        = (cursor_reg == count_reg) ? '0 : cursor_reg;
                end
            end
            default:
            begin
                dec_err = 1'b1;
            end
        endcase
    end

    always_comb
    begin
        state_next        = state_reg;
        wait_next         = wait_reg;
        count_next        = count_reg;
        cursor_next       = cursor_reg;
        err_next          = err_reg;
        result_valid_next = result_valid_reg && result_stall;
        result_next       = result_reg;
        cmd               = '0;
        if (accept)
        begin
            state_next  = ST_RUN;
            wait_next   = '0;
            count_next  = dec_count;
            cursor_next = dec_cursor;
            err_next    = dec_err;
            cmd         = dec_cmd;
        end
        else if ((state_reg == ST_RUN) && !done)
        begin
            wait_next = wait_reg + CW'(1);
        end
        if (load)
        begin
            state_next                = ST_IDLE;
            result_valid_next         = 1'b1;
            result_next.current_value = col_wide[31:0];
            result_next.has_item      = (cursor_reg != '0);
            result_next.entry_count   = 5'(count_reg);
            result_next.error_flag    = err_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= ST_IDLE;
            wait_reg         <= '0;
            count_reg        <= '0;
            cursor_reg       <= '0;
            err_reg          <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            wait_reg         <= wait_next;
            count_reg        <= count_next;
            cursor_reg       <= cursor_next;
            err_reg          <= err_next;
            result_valid_reg <= result_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        result_reg <= result_next;
    end

    assign pos          = dec_pos;
    assign cursor       = cursor_reg;
    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CW'(DEPTH))
        else $error("entry count beyond depth");

    a_cursor_range: assert property (@(posedge clk) disable iff (!rst_n)
        cursor_reg <= count_reg)
        else $error("cursor beyond last entry");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> item_stall)
        else $error("item beat taken while busy");

    a_state_held: assert property (@(posedge clk) disable iff (!rst_n)
        !accept |=> ($stable(count_reg) && $stable(cursor_reg)))
        else $error("count or cursor moved without an item beat");

    a_result_from_run: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(result_valid_reg) |-> $past(state_reg == ST_RUN))
        else $error("result raised outside a run");

endmodule
